// ----- hw/rtl/gpls_pkg.sv -----
// Shared types and constants for the grid point locator.
// No dependencies.
package gpls_pkg;
    localparam int FracBits = 24;
    localparam int MaxPoints = 255;
    localparam int NumAxes = 5;
    localparam int NumRegs = 6;
    localparam int CfgW = 63;
    localparam int InW = 160;
    localparam int OutW = 42;
    localparam int QueueDepth = 2;

    localparam logic [2:0] RegSetupS = 3'd0;
    localparam logic [2:0] RegSetupP = 3'd1;
    localparam logic [2:0] RegSetupA = 3'd2;
    localparam logic [2:0] RegSetupC = 3'd3;
    localparam logic [2:0] RegSetupG = 3'd4;
    localparam logic [2:0] RegCounts = 3'd5;

    // Doubled grid values and distances, wide enough for all inputs
    localparam int GW = 44;

    typedef struct packed {
        logic [4:0][7:0] idx;
        logic            clamped;
        logic [2:0][31:0] val;
    } t_job;

    localparam int JobW = $bits(t_job);
endpackage

// ----- hw/rtl/gpls_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gpls_ram #(
    parameter int Width = 8,
    parameter int Depth = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hw/rtl/gpls_front.sv -----
// Front end: computes the five clamped grid indices by restoring division.
// Depends on gpls_pkg.
module gpls_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [159:0]         i_data,
    input  logic [4:0][62:0]     i_setup,
    input  logic [39:0]          i_counts,
    output logic                 o_valid,
    input  logic                 i_ready,
    output gpls_pkg::t_job       o_job
);
    typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_DONE} t_state;

    t_state              r_state;
    logic [2:0]          r_axis;
    logic [5:0]          r_bit;
    logic [159:0]        r_data;
    logic [33:0]         r_rem;
    logic [33:0]         r_quot;
    logic                r_neg;
    logic [4:0][7:0]     r_idx;
    logic                r_clamp;

    logic signed [32:0] w_diff;
    logic [30:0]        w_step;
    logic [7:0]         w_cnt;
    logic [8:0]         w_n;
    logic [34:0]        w_trial;
    logic [34:0]        w_qa;
    logic signed [35:0] w_q;
    logic [7:0]         w_qc;
    logic               w_cl;

    always_comb begin
        w_diff = 33'(signed'(r_data[r_axis*32 +: 32])) -
                 33'(signed'(i_setup[r_axis][31:0]));
        w_step = i_setup[r_axis][62:32];
        w_cnt = i_counts[r_axis*8 +: 8];
        w_n = (w_cnt < 8'd2) ? 9'd2 : {1'b0, w_cnt};
        w_trial = {r_rem[32:0], r_quot[r_bit]} - {4'd0, w_step};
        // Floor for negatives: magnitude floor, plus one if remainder non-zero, then negated
        w_qa = {1'b0, r_quot} + ((r_neg && r_rem != 34'd0) ? 35'd1 : 35'd0);
        w_q = r_neg ? -36'(signed'({1'b0, w_qa})) : 36'(signed'({1'b0, w_qa}));
        w_cl = 1'b0;
        w_qc = r_quot[7:0];
        if (w_step == 31'd0) begin
            w_cl = 1'b1;
            w_qc = w_diff < 0 ? 8'd0 : 8'(w_n - 9'd1);
        end else if (w_q < 0) begin
            w_cl = 1'b1;
            w_qc = 8'd0;
        end else if (w_q >= 36'(w_n)) begin
            w_cl = 1'b1;
            w_qc = 8'(w_n - 9'd1);
        end else begin
            w_qc = w_q[7:0];
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_DONE);

    always_comb begin
        o_job.idx = r_idx;
        o_job.clamped = r_clamp;
        o_job.val = r_data[159:64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_data  <= i_data;
                        r_axis  <= 3'd0;
                        r_clamp <= 1'b0;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // load magnitude as dividend bits, shift in from the top
                    r_neg  <= w_diff < 0;
                    r_quot <= w_diff < 0 ? 34'(-w_diff) : 34'(w_diff);
                    r_rem  <= 34'd0;
                    r_bit  <= 6'd33;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_bit == 6'd63) begin
                        r_idx[r_axis] <= w_qc;
                        r_clamp <= r_clamp | w_cl;
                        if (r_axis == 3'd4) begin
                            r_state <= S_DONE;
                        end else begin
                            r_axis  <= r_axis + 3'd1;
                            r_state <= S_PREP;
                        end
                    end else begin
                        if (w_trial[34] || w_step == 31'd0) begin
                            r_rem <= {r_rem[32:0], r_quot[r_bit]};
                            r_quot[r_bit] <= 1'b0;
                        end else begin
                            r_rem <= w_trial[33:0];
                            r_quot[r_bit] <= 1'b1;
                        end
                        r_bit <= (r_bit == 6'd0) ? 6'd63 : r_bit - 6'd1;
                    end
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/gpls_back.sv -----
// Back end: walks indices 2..4 down until grid sum < 1 or the chosen one is 0.
// Depends on gpls_pkg.
module gpls_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gpls_pkg::t_job    i_job,
    input  logic [4:0][62:0]  i_setup,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [47:0]       o_tdata
);
    localparam int GW = gpls_pkg::GW;
    localparam logic signed [GW-1:0] One2 = GW'(2) <<< gpls_pkg::FracBits;

    typedef enum logic [1:0] {S_IDLE, S_SUM, S_STEP, S_OUT} t_state;

    t_state          r_state;
    gpls_pkg::t_job  r_job;
    logic            r_status;
    logic [1:0]      r_sel;

    logic signed [GW-1:0] w_g [3];
    logic signed [GW-1:0] w_d [3];
    logic signed [GW-1:0] w_sum;
    logic [1:0]           w_sel;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [GW-1:0] mn;
            logic signed [GW-1:0] st;
            logic signed [GW-1:0] ix;
            mn = GW'(signed'(i_setup[k+2][31:0]));
            st = GW'({1'b0, i_setup[k+2][62:32]});
            ix = GW'({1'b0, r_job.idx[k+2]});
            w_g[k] = 2 * mn + (2 * ix + 1) * st;
            w_d[k] = (r_job.idx[k+2] != 8'd0)
                   ? 2 * GW'(signed'(r_job.val[k])) - (w_g[k] - 2 * st) : One2;
        end
        w_sum = w_g[0] + w_g[1] + w_g[2];
        if (w_d[0] < w_d[1]) begin
            w_sel = (w_d[0] < w_d[2]) ? 2'd0 : 2'd2;
        end else begin
            w_sel = (w_d[1] < w_d[2]) ? 2'd1 : 2'd2;
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_tvalid = (r_state == S_OUT);
    assign o_tdata  = {6'd0, r_status, r_job.clamped, r_job.idx[4], r_job.idx[3],
                       r_job.idx[2], r_job.idx[1], r_job.idx[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job    <= i_job;
                        r_status <= 1'b0;
                        r_state  <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (w_sum >= One2) begin
                        r_sel   <= w_sel;
                        r_state <= S_STEP;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_STEP: begin
                    if (r_job.idx[{1'b0, r_sel} + 3'd2] == 8'd0) begin
                        r_status <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_job.idx[{1'b0, r_sel} + 3'd2] <=
                            r_job.idx[{1'b0, r_sel} + 3'd2] - 8'd1;
                        r_state <= S_SUM;
                    end
                end
                S_OUT: begin
                    if (i_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/gpls_queue.sv -----
// Two-entry job queue between front and back ends, held in the generic RAM.
// Depends on gpls_pkg and gpls_ram.
module gpls_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  gpls_pkg::t_job  i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output gpls_pkg::t_job  o_job
);
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       r_ovalid;
    logic       w_push;
    logic       w_pop;
    logic       w_load;
    logic [gpls_pkg::JobW-1:0] w_rd;

    // Registered read: stage the head into the output once it is stable
    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign w_load  = !r_ovalid && (r_cnt != 2'd0) && !w_push;
    assign o_valid = r_ovalid;
    assign o_job   = w_rd;

    gpls_ram #(.Width(gpls_pkg::JobW), .Depth(gpls_pkg::QueueDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_push),
        .i_waddr(r_wp),
        .i_wdata(i_job),
        .i_raddr(r_rp),
        .o_rdata(w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
                r_ovalid <= 1'b0;
            end else if (w_load) begin
                r_ovalid <= 1'b1;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ----- hw/rtl/grid_point_locator_simplex.sv -----
// Top level of the five-axis grid point locator with the simplex walk.
// Depends on gpls_pkg, gpls_front, gpls_queue and gpls_back.
//
// Channels: s_axis carries one parameter point, m_axis one result per point,
// cfg writes the six setup registers (index 0..5, others ignored).
// The front end runs the five axes in turn through a bit-serial restoring
// divider; s_axis_tready is high only while the front end is idle, so a new
// point is taken only once the last one has left the front end. The back end
// makes each walk pass through its sum and step states. A two-entry queue
// lets the front divide the next point while the back walks or waits on a
// stalled receiver; a stalled m_axis holds its result and, once the queue
// fills, the front end holds its finished point and s_axis_tready stays low.
// Reset (synchronous, active low) empties the queue, idles both ends and
// loads the register defaults: minimum 0, step 1/16, 16 points per axis.
// Write configuration only while the block is idle.
module grid_point_locator_simplex (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // value_s, value_p, value_a, value_c, value_g
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // index_s, index_p, index_a, index_c, index_g, was_clamped, status, pad
    output logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [62:0]  i_cfg_data
);
    logic [4:0][62:0] r_setup;
    logic [39:0]      r_counts;

    logic           w_fv;
    logic           w_fr;
    gpls_pkg::t_job w_fjob;
    logic           w_qv;
    logic           w_qr;
    gpls_pkg::t_job w_qjob;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_setup[k] <= 63'd4503599627370496;
            end
            r_counts <= 40'd68988964880;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == gpls_pkg::RegCounts) begin
                r_counts <= i_cfg_data[39:0];
            end else if (i_cfg_index < gpls_pkg::RegCounts) begin
                r_setup[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    gpls_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .i_setup(r_setup), .i_counts(r_counts),
        .o_valid(w_fv), .i_ready(w_fr), .o_job(w_fjob)
    );

    gpls_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fv), .o_ready(w_fr), .i_job(w_fjob),
        .o_valid(w_qv), .i_ready(w_qr), .o_job(w_qjob)
    );

    gpls_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_job(w_qjob), .i_setup(r_setup),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready), .o_tdata(m_axis_tdata)
    );
endmodule
